// ===== rtl/silc_pkg.sv =====
// Operation and status codes shared by the sorted id list cursor.
`timescale 1ns / 1ps
package silc_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ID_W     = 64;

  // operation codes carried in the slave-side tuser
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_SKIP   = 3'd3;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
  localparam logic [OP_W-1:0] OP_ABORT  = 3'd5;

  // status codes carried in the master-side tuser
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_END      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

// ===== rtl/silc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module silc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sorted_id_list_cursor_top.sv =====
// Top level of the sorted id list cursor: control, search sequencer and output register.
`timescale 1ns / 1ps
// Cursor over an ascending list of 64-bit document ids held in one RAM.
// Slave side: tuser carries the operation, tdata the id (append for load,
// target for skip). Master side: one transaction per accepted item; tuser
// carries the status, tdata the returned id and the number of loaded ids.
// Clear, load, rewind, abort, unused codes and an end of list seen at
// acceptance finish without a RAM read; read next does one RAM read; skip
// first reads the last stored id, then halves the range from the cursor
// to the last entry until it lands on the first id not below the target.
// All reads use the single RAM read port; one item is worked at a time
// and tready stays high whenever no item is in progress, also while a
// result waits in the output register. When the receiver stalls, a finished
// result is held in a second result register and no further item is taken
// until the output register has room. Reset empties the list, rewinds the
// cursor, clears the last id and marks the list valid; the RAM is not
// cleared, since entries are read only below the fill count.
module sorted_id_list_cursor_top #(
  parameter int unsigned MAX_IDS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // [63:0] id_value
  input  logic [silc_pkg::OP_W-1:0]       s_axis_tuser,  // [2:0] operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] doc_id, then entry_total, zero fill to whole bytes
  output logic [((64+$clog2(MAX_IDS+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic [silc_pkg::STATUS_W-1:0]   m_axis_tuser   // [2:0] status
);

  import silc_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_IDS);
  localparam int unsigned CNT_W = $clog2(MAX_IDS + 1);
  localparam int unsigned OUT_W = ((64 + CNT_W + 7) / 8) * 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    cursor_q, cursor_d;
  logic [ID_W-1:0]     last_q, last_d;
  logic                valid_q, valid_d;
  logic [ID_W-1:0]     tgt_q, tgt_d;
  logic [IDX_W-1:0]    lo_q, lo_d;
  logic [IDX_W-1:0]    hi_q, hi_d;
  logic [IDX_W-1:0]    mid_q, mid_d;
  logic [ID_W-1:0]     hival_q, hival_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [ID_W-1:0]     res_doc_q, res_doc_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [ID_W-1:0]     out_doc_q, out_doc_d;
  logic [CNT_W-1:0]    out_total_q, out_total_d;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ID_W-1:0]     ram_rdata;

  logic                acc, out_free, list_end;
  logic [IDX_W-1:0]    cur_idx, last_idx;
  logic [IDX_W-1:0]    nlo, nhi, nmid;
  logic [ID_W-1:0]     nhv;
  logic [CNT_W-1:0]    ncur;
  logic                fin;
  logic [STATUS_W-1:0] fin_status;
  logic [ID_W-1:0]     fin_doc;

  silc_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_IDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(s_axis_tdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign list_end      = !valid_q || (cursor_q >= count_q);
  assign cur_idx       = cursor_q[IDX_W-1:0];
  assign last_idx      = IDX_W'(count_q - CNT_W'(1));

  // one halving step: the first pass starts from the cursor and the last entry
  always_comb begin
    if (state_q == S_CHK) begin
      nlo = cur_idx;
      nhi = last_idx;
      nhv = ram_rdata;
    end else if (ram_rdata < tgt_q) begin
      nlo = mid_q + IDX_W'(1);
      nhi = hi_q;
      nhv = hival_q;
    end else begin
      nlo = lo_q;
      nhi = mid_q;
      nhv = ram_rdata;
    end
  end

  assign nmid = nlo + ((nhi - nlo) >> 1);
  assign ncur = CNT_W'(nhi) + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    last_d       = last_q;
    valid_d      = valid_q;
    tgt_d        = tgt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    hival_d      = hival_q;
    res_status_d = res_status_q;
    res_doc_d    = res_doc_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_doc_d    = out_doc_q;
    out_total_d  = out_total_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cur_idx;
    fin          = 1'b0;
    fin_status   = ST_DONE;
    fin_doc      = last_q;

    // drop the result once the receiver takes it
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          tgt_d = s_axis_tdata;
          unique case (s_axis_tuser)
            OP_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
              last_d   = '0;
              valid_d  = 1'b1;
              fin      = 1'b1;
              fin_doc  = '0;
            end
            OP_LOAD: begin
              fin = 1'b1;
              if (count_q < CNT_W'(MAX_IDS)) begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end else begin
                fin_status = ST_FULL;
              end
            end
            OP_READ: begin
              if (list_end) begin
                valid_d    = 1'b0;
                fin        = 1'b1;
                fin_status = ST_END;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cur_idx;
                state_d   = S_RD;
              end
            end
            OP_SKIP: begin
              if (list_end) begin
                fin        = 1'b1;
                fin_status = ST_END;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = last_idx;
                state_d   = S_CHK;
              end
            end
            OP_REWIND: begin
              valid_d  = 1'b1;
              cursor_d = '0;
              last_d   = '0;
              fin      = 1'b1;
              fin_doc  = '0;
            end
            OP_ABORT: begin
              valid_d = 1'b0;
              fin     = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        last_d     = ram_rdata;
        cursor_d   = cursor_q + CNT_W'(1);
        fin        = 1'b1;
        fin_status = ST_OK;
        fin_doc    = ram_rdata;
      end
      S_CHK, S_SRCH: begin
        if ((state_q == S_CHK) && (tgt_q > ram_rdata)) begin
          // target beyond the last stored id
          valid_d    = 1'b0;
          fin        = 1'b1;
          fin_status = ST_END;
        end else if (nlo < nhi) begin
          lo_d      = nlo;
          hi_d      = nhi;
          hival_d   = nhv;
          mid_d     = nmid;
          ram_re    = 1'b1;
          ram_raddr = nmid;
          state_d   = S_SRCH;
        end else begin
          // the upper bound always holds the id at the landing index
          cursor_d   = ncur;
          last_d     = nhv;
          fin        = 1'b1;
          fin_doc    = nhv;
          fin_status = (nhv == tgt_q) ? ST_OK : ST_NOTFOUND;
          if (ncur >= count_q) begin
            valid_d = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_doc_d    = res_doc_q;
          out_total_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hand a finished result to the output register, or park it
    if (fin) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_status_d = fin_status;
        out_doc_d    = fin_doc;
        out_total_d  = count_d;
        state_d      = S_IDLE;
      end else begin
        res_status_d = fin_status;
        res_doc_d    = fin_doc;
        state_d      = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      last_q      <= '0;
      valid_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      last_q      <= last_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q        <= tgt_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    hival_q      <= hival_d;
    res_status_q <= res_status_d;
    res_doc_q    <= res_doc_d;
    out_status_q <= out_status_d;
    out_doc_q    <= out_doc_d;
    out_total_q  <= out_total_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_W'({out_total_q, out_doc_q});

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the sorted id list cursor: directed, capacity, random and backpressure tests.
`timescale 1ns / 1ps
module testbench;
  import silc_pkg::*;

  localparam int unsigned MAX_IDS        = 1024;
  localparam int unsigned CNT_W          = $clog2(MAX_IDS + 1);
  localparam int unsigned DATA_W         = ((64 + CNT_W + 7) / 8) * 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 32;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 40;

  // codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [63:0]         doc_id;
    logic [CNT_W-1:0]    entry_total;
  } cursor_reply_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;
  logic [OP_W-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  sorted_id_list_cursor_top #(
    .MAX_IDS(MAX_IDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial forever #6 clk_i = ~clk_i;

  // predicted list state
  logic [63:0]   list_ids [MAX_IDS];
  int unsigned   list_len  = 0;
  int unsigned   list_pos  = 0;
  logic [63:0]   last_doc  = '0;
  bit            list_live = 1'b1;

  cursor_reply_t cursor_reply_q[$];
  int unsigned   items_sent     = 0;
  int unsigned   err_count      = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   recv_stall_pct  = 0;
  int unsigned   hold_token     = 0;
  int unsigned   hold_taken     = 0;
  int unsigned   hold_left      = 0;

  function automatic logic [63:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  function automatic cursor_reply_t predict_cursor_reply(input logic [OP_W-1:0] op,
                                                        input logic [63:0] id);
    cursor_reply_t r;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    r.status = ST_DONE;
    r.doc_id = last_doc;
    case (op)
      OP_CLEAR: begin
        list_len  = 0;
        list_pos  = 0;
        last_doc  = '0;
        list_live = 1'b1;
        r.doc_id  = '0;
      end
      OP_LOAD: begin
        if (list_len < MAX_IDS) begin
          list_ids[list_len] = id;
          list_len++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_READ: begin
        if (!list_live || list_pos >= list_len) begin
          list_live = 1'b0;
          r.status  = ST_END;
        end else begin
          last_doc = list_ids[list_pos];
          list_pos++;
          r.doc_id = last_doc;
          r.status = ST_OK;
        end
      end
      OP_SKIP: begin
        if (!list_live || list_pos >= list_len) begin
          r.status = ST_END;
        end else if (id > list_ids[list_len - 1]) begin
          list_live = 1'b0;
          r.status  = ST_END;
        end else begin
          // lower bound by halving from the cursor to the last entry
          lo = list_pos;
          hi = list_len - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (list_ids[mid] < id) lo = mid + 1;
            else hi = mid;
          end
          list_pos = lo + 1;
          if (list_pos >= list_len) list_live = 1'b0;
          last_doc = list_ids[lo];
          r.doc_id = last_doc;
          r.status = (last_doc == id) ? ST_OK : ST_NOTFOUND;
        end
      end
      OP_REWIND: begin
        list_live = 1'b1;
        list_pos  = 0;
        last_doc  = '0;
        r.doc_id  = '0;
      end
      OP_ABORT: list_live = 1'b0;
      default: ;
    endcase
    r.entry_total = CNT_W'(list_len);
    return r;
  endfunction

  function automatic logic [63:0] pick_target();
    int unsigned k;
    if (list_len == 0) return rand_id();
    k = $urandom_range(list_len - 1);
    case ($urandom_range(5))
      0, 1: return list_ids[k];
      2: return list_ids[k] - 64'd1;
      3: return list_ids[k] + 64'd1;
      4: return list_ids[list_len - 1] + 64'd1;
      default: return rand_id();
    endcase
  endfunction

  // Offer one item; return in the time step of its acceptance.
  task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [63:0] id);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= id;
    do @(posedge clk_i); while (!s_axis_tready);
    cursor_reply_q.push_back(predict_cursor_reply(op, id));
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (cursor_reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    err_count++;
    if (err_count <= 10)
      $display("mismatch %s: expected %0h actual %0h", what, exp_v, act_v);
  endtask

  // Receiver: random stalls, long hold-off on request, result checking.
  always @(posedge clk_i) begin
    cursor_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cursor_reply_q.size() == 0) begin
        note_mismatch("unexpected transaction", '0, m_axis_tdata[63:0]);
      end else begin
        want = cursor_reply_q.pop_front();
        if (m_axis_tuser !== want.status)
          note_mismatch("status", 64'(want.status), 64'(m_axis_tuser));
        if (m_axis_tdata[63:0] !== want.doc_id)
          note_mismatch("doc_id", want.doc_id, m_axis_tdata[63:0]);
        if (m_axis_tdata[64 +: CNT_W] !== want.entry_total)
          note_mismatch("entry_total", 64'(want.entry_total), 64'(m_axis_tdata[64 +: CNT_W]));
      end
    end
    if (hold_taken != hold_token) begin
      hold_taken    <= hold_token;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("sorted_id_list_cursor_top regression: fail");
    $finish;
  end

  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    issue_cmd(OP_READ, '0);            // empty list: end, goes invalid
    issue_cmd(OP_SKIP, '0);            // invalid: end, no change
    issue_cmd(OP_CLEAR, '1);
    issue_cmd(OP_SPARE_6, '1);
    issue_cmd(OP_SPARE_7, '0);
    issue_cmd(OP_LOAD, 64'd0);
    issue_cmd(OP_LOAD, 64'd5);
    issue_cmd(OP_LOAD, 64'd5);
    issue_cmd(OP_LOAD, 64'd100);
    issue_cmd(OP_LOAD, '1);
    issue_cmd(OP_READ, '0);
    issue_cmd(OP_SKIP, 64'd5);         // exact hit on a duplicate
    issue_cmd(OP_SKIP, 64'd50);        // miss, lands on the next larger id
    issue_cmd(OP_SKIP, '1);            // hit on last entry, cursor runs off the end
    issue_cmd(OP_READ, '0);
    issue_cmd(OP_REWIND, '1);
    issue_cmd(OP_SKIP, 64'd6);
    issue_cmd(OP_CLEAR, '0);
    issue_cmd(OP_LOAD, 64'd10);
    issue_cmd(OP_LOAD, 64'd20);
    issue_cmd(OP_SKIP, 64'd21);        // target above last id
    issue_cmd(OP_SKIP, 64'd5);
    issue_cmd(OP_REWIND, '0);
    issue_cmd(OP_SKIP, 64'd0);
    issue_cmd(OP_ABORT, '1);
    issue_cmd(OP_READ, '0);
    issue_cmd(OP_REWIND, '0);
    issue_cmd(OP_READ, '1);
    drain_results();
  endtask

  task automatic test_fill_to_capacity();
    logic [63:0] v;
    int unsigned pick;
    sender_idle_pct = 30;
    recv_stall_pct  = 30;
    issue_cmd(OP_CLEAR, '0);
    v = rand_id() >> 12;
    repeat (MAX_IDS) begin
      issue_cmd(OP_LOAD, v);
      v = v + 64'($urandom_range(4));
    end
    issue_cmd(OP_LOAD, rand_id());     // store full
    issue_cmd(OP_LOAD, rand_id());
    repeat (40) begin
      pick = $urandom_range(99);
      if (pick < 60) issue_cmd(OP_SKIP, pick_target());
      else if (pick < 85) issue_cmd(OP_READ, rand_id());
      else issue_cmd(OP_REWIND, rand_id());
    end
    issue_cmd(OP_REWIND, '0);
    issue_cmd(OP_SKIP, list_ids[MAX_IDS - 1]);
    drain_results();
  endtask

  // Mostly well-formed lists with random content, some noise items.
  task automatic test_random_lists(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    logic [63:0] v;
    logic [63:0] step;
    bit          unordered;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        issue_cmd(OP_W'($urandom_range(7)), rand_id());
      end else begin
        issue_cmd(OP_CLEAR, rand_id());
        len       = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
        unordered = ($urandom_range(7) == 0);
        v         = rand_id() >> $urandom_range(63);
        repeat (len) begin
          issue_cmd(OP_LOAD, v);
          if (unordered) begin
            v = rand_id();
          end else begin
            step = ($urandom_range(3) == 0) ? (rand_id() >> $urandom_range(8, 63))
                                            : 64'($urandom_range(2));
            // saturate instead of wrapping
            v = (v + step < v) ? '1 : v + step;
          end
        end
        repeat ($urandom_range(4, 24)) begin
          pick = $urandom_range(99);
          if (pick < 45) issue_cmd(OP_SKIP, pick_target());
          else if (pick < 75) issue_cmd(OP_READ, rand_id());
          else if (pick < 83) issue_cmd(OP_REWIND, rand_id());
          else if (pick < 88) issue_cmd(OP_ABORT, rand_id());
          else if (pick < 94)
            issue_cmd(OP_LOAD, (list_len != 0) ? list_ids[list_len - 1] + 64'($urandom_range(3))
                                               : rand_id());
          else issue_cmd(OP_SKIP, rand_id());
        end
      end
    end
    drain_results();
  endtask

  task automatic test_idle_phases();
    sender_idle_pct = 0;  recv_stall_pct = 0;  test_random_lists(PHASE_ITEMS);
    sender_idle_pct = 66; recv_stall_pct = 0;  test_random_lists(PHASE_ITEMS);
    sender_idle_pct = 0;  recv_stall_pct = 66; test_random_lists(PHASE_ITEMS);
    sender_idle_pct = 30; recv_stall_pct = 30; test_random_lists(PHASE_ITEMS);
  endtask

  // Hold the output off while items keep coming, so the input stalls.
  task automatic test_output_holdoff();
    logic [63:0] v;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_token <= hold_token + 1;
    issue_cmd(OP_CLEAR, '0);
    v = rand_id() >> 8;
    repeat (8) begin
      issue_cmd(OP_LOAD, v);
      v = v + 64'($urandom_range(1, 1000));
    end
    repeat (16) begin
      if ($urandom_range(1) == 0) issue_cmd(OP_SKIP, pick_target());
      else issue_cmd(OP_READ, rand_id());
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_to_capacity();
    test_idle_phases();
    test_output_holdoff();
    err_count += cursor_reply_q.size();
    if (err_count == 0) begin
      $display("sorted_id_list_cursor_top regression: pass");
    end else begin
      $display("sorted_id_list_cursor_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/silc_pkg.sv
rtl/silc_ram.sv
rtl/sorted_id_list_cursor_top.sv
verif/testbench.sv
